FILE: design/spectral_peak_picker_top_n_core_macros.svh
// Assertion macros for the spectral peak picker
`ifndef SPECTRAL_PEAK_PICKER_TOP_N_CORE_MACROS_SVH
`define SPECTRAL_PEAK_PICKER_TOP_N_CORE_MACROS_SVH
`ifndef ASSERT_OFF
`define SPP_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define SPP_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define SPP_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`define SPP_ASSERT_NXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

FILE: design/spp_pkg.sv
// Shared types and constants for the spectral peak picker
`timescale 1ns / 1ps
package spp_pkg;
    localparam int MaxBins   = 4096;
    localparam int MaxPeaks  = 32;
    localparam int BinW      = 12;
    localparam int IdxW      = 5;
    localparam int CntW      = 6;
    localparam logic [16:0] ValSat = 17'd131071;

    localparam logic CFG_WANTED = 1'b0;
    localparam logic CFG_THRESH = 1'b1;

    // commands from the controller to the datapath
    typedef struct packed {
        logic take_bin;     // latch bin and update frame tracking
        logic div_start;    // start the interpolation divides
        logic ins_start;    // begin insertion of the pending peak
        logic out_load;     // load the output count from the peak list count
        logic out_next;     // advance output pointer
        logic frame_clear;  // end of frame
    } t_cmd;

    // status from the datapath to the controller
    typedef struct packed {
        logic have_peak;    // a plain peak is pending
        logic have_refine;  // a parabolic peak is pending
        logic have_edge;    // a final-bin rising peak also pending
        logic div_done;
        logic ins_done;
        logic is_last;
        logic out_last;
        logic out_empty;
    } t_sts;
endpackage

FILE: design/spp_divider.sv
// Radix-2 restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps
module spp_divider (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [37:0] i_num,
    input  logic [20:0] i_den,
    output logic        o_done,
    output logic [37:0] o_quo
);
    logic [37:0] r_quo;
    logic [20:0] r_rem;
    logic [20:0] r_den;
    logic [5:0]  r_cnt;
    logic        r_busy;
    logic        r_done;
    logic [21:0] w_trial;

    assign w_trial = {r_rem, r_quo[37]} - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 6'd38;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 6'd1;
                if (r_cnt == 6'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            if (!w_trial[21]) begin
                r_rem <= w_trial[20:0];
                r_quo <= {r_quo[36:0], 1'b1};
            end else begin
                r_rem <= {r_rem[19:0], r_quo[37]};
                r_quo <= {r_quo[36:0], 1'b0};
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;
endmodule

FILE: design/spp_datapath.sv
// Datapath: frame tracking, interpolation and sorted peak list
`timescale 1ns / 1ps
`include "spectral_peak_picker_top_n_core_macros.svh"
module spp_datapath (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  spp_pkg::t_cmd      i_cmd,
    output spp_pkg::t_sts      o_sts,
    input  logic [15:0]        i_magnitude,
    input  logic               i_last_bin,
    input  logic [5:0]         i_wanted,
    input  logic [15:0]        i_thresh,
    output logic [15:0]        o_peak_position,
    output logic [16:0]        o_peak_value,
    output logic               o_peak_present
);
    logic [spp_pkg::BinW-1:0] r_bin_cnt;
    logic [15:0] r_prev0, r_prev1;
    logic [spp_pkg::BinW-1:0] r_plat;
    logic r_rising;
    logic [spp_pkg::CntW-1:0] r_count;
    logic [16:0] r_val [spp_pkg::MaxPeaks];
    logic [15:0] r_pos [spp_pkg::MaxPeaks];

    // pending peak
    logic r_have_peak, r_have_ref, r_have_edge, r_last;
    logic [15:0] r_pk_pos, r_edge_pos;
    logic [16:0] r_pk_val;
    logic [15:0] r_edge_val;
    // interpolation operands
    logic [16:0] r_a;
    logic [17:0] r_d;
    logic        r_neg;
    logic [15:0] r_mid;
    logic [15:0] r_jpos;
    logic        r_pass;     // 0: position divide, 1: value divide
    logic [37:0] r_frac;

    // insertion
    logic        r_ins_busy, r_ins_done;
    logic [spp_pkg::CntW-1:0] r_k, r_idx;
    logic [1:0]  r_ins_ph;
    logic [16:0] r_ins_val;
    logic [15:0] r_ins_pos;
    logic [spp_pkg::CntW-1:0] r_out_ptr, r_out_cnt;

    logic [spp_pkg::CntW-1:0] w_cap;
    logic        w_last;
    logic [16:0] w_p;
    logic        div_start, div_done;
    logic [37:0] div_num, div_quo;
    logic [20:0] div_den;
    logic [33:0] w_asq;
    logic [18:0] w_posi;
    logic [17:0] w_vsum;

    assign w_cap = (i_wanted == '0) ? 6'd1 :
                   (i_wanted > 6'(spp_pkg::MaxPeaks)) ? 6'(spp_pkg::MaxPeaks) : i_wanted;
    assign w_last = i_last_bin || (r_bin_cnt == 12'(spp_pkg::MaxBins - 1));
    assign w_p = {1'b0, r_prev0};

    // frame tracking and peak detection
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.frame_clear) begin
            r_bin_cnt <= '0; r_prev0 <= '0; r_prev1 <= '0;
            r_plat <= '0; r_rising <= 1'b0;
            r_have_peak <= 1'b0; r_have_ref <= 1'b0; r_have_edge <= 1'b0;
            r_last <= 1'b0;
        end else if (i_cmd.take_bin) begin
            r_have_peak <= 1'b0; r_have_ref <= 1'b0; r_have_edge <= 1'b0;
            r_last <= w_last;
            if (r_bin_cnt != '0) begin
                if (r_bin_cnt == 12'd1 && r_prev0 > i_magnitude && r_prev0 > i_thresh) begin
                    r_have_peak <= 1'b1;
                    r_pk_pos <= '0;
                    r_pk_val <= w_p;
                end
                if (r_bin_cnt >= 12'd2 && i_magnitude < r_prev0 && r_rising
                        && r_prev0 > i_thresh) begin
                    if (r_plat == r_bin_cnt - 12'd1) begin
                        r_have_ref <= 1'b1;
                        r_neg  <= r_prev1 > i_magnitude;
                        r_a    <= (r_prev1 > i_magnitude) ? 17'(r_prev1 - i_magnitude)
                                                          : 17'(i_magnitude - r_prev1);
                        r_d    <= 18'({r_prev0, 1'b0}) - 18'(r_prev1) - 18'(i_magnitude);
                        r_mid  <= r_prev0;
                        r_jpos <= {r_plat, 4'd0};
                    end else if (!w_last) begin
                        r_have_peak <= 1'b1;
                        r_pk_pos <= 16'({1'b0, r_plat} + {1'b0, r_bin_cnt - 12'd1}) << 3;
                        r_pk_val <= w_p;
                    end
                end
                if (i_magnitude < r_prev0) r_rising <= 1'b0;
                else if (i_magnitude > r_prev0) begin
                    r_rising <= 1'b1;
                    r_plat <= r_bin_cnt;
                end
                if (w_last && i_magnitude > r_prev0 && i_magnitude > i_thresh) begin
                    r_have_edge <= 1'b1;
                    r_edge_pos <= {r_bin_cnt, 4'd0};
                    r_edge_val <= i_magnitude;
                end
            end
            r_prev1 <= r_prev0;
            r_prev0 <= i_magnitude;
            r_bin_cnt <= r_bin_cnt + 12'd1;
        end else if (div_done && r_pass) begin
            // refined peak ready: hand it on as a plain pending peak
            r_have_ref  <= 1'b0;
            r_have_peak <= 1'b1;
            r_pk_pos <= w_posi[18] ? 16'd0 : w_posi[15:0];
            r_pk_val <= (div_quo[37:17] != '0 || w_vsum[17]) ? spp_pkg::ValSat
                                                              : w_vsum[16:0];
        end else if (i_cmd.ins_start) begin
            // consume pending peaks in order: plain/refined, then edge
            if (r_have_peak || r_have_ref) begin
                r_have_peak <= 1'b0; r_have_ref <= 1'b0;
            end else r_have_edge <= 1'b0;
        end
    end

    // interpolation: position divide then value divide
    assign w_asq = r_a * r_a;
    assign div_start = i_cmd.div_start || (div_done && !r_pass);
    assign div_num = !r_pass && !div_done ? 38'({r_a, 4'd0}) + 38'(r_d)
                   : 38'(w_asq) + 38'({r_d, 2'b0});
    assign div_den = !r_pass && !div_done ? 21'({r_d, 1'b0}) : 21'({r_d, 3'b0});
    spp_divider u_div (.i_clk, .i_rst_n, .i_start(div_start), .i_num(div_num),
                       .i_den(div_den), .o_done(div_done), .o_quo(div_quo));

    assign w_posi = r_neg ? 19'(r_jpos) - 19'(r_frac[15:0]) : 19'(r_jpos) + 19'(r_frac[15:0]);
    assign w_vsum = 18'(div_quo[16:0]) + 18'(r_mid);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_pass <= 1'b0;
        else if (i_cmd.div_start) r_pass <= 1'b0;
        else if (div_done) begin
            if (!r_pass) begin
                r_pass <= 1'b1;
                r_frac <= div_quo;
            end else begin
                r_pass <= 1'b0;
            end
        end
    end

    // sorted insertion: find index, then shift down one entry per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.frame_clear) begin
            r_count <= '0; r_ins_busy <= 1'b0; r_ins_done <= 1'b0;
            r_ins_ph <= 2'd0; r_k <= '0; r_idx <= '0;
        end else begin
            r_ins_done <= 1'b0;
            if (i_cmd.ins_start) begin
                r_ins_busy <= 1'b1;
                r_ins_ph <= 2'd0;
                r_idx <= '0;
                r_ins_val <= (r_have_peak || r_have_ref) ? r_pk_val : {1'b0, r_edge_val};
                r_ins_pos <= (r_have_peak || r_have_ref) ? r_pk_pos : r_edge_pos;
                if (r_count > w_cap) r_count <= w_cap;
            end else if (r_ins_busy) begin
                if (r_ins_ph == 2'd0) begin
                    if (r_idx < r_count && r_val[r_idx[spp_pkg::IdxW-1:0]] >= r_ins_val)
                        r_idx <= r_idx + 6'd1;
                    else if (r_idx >= w_cap) begin
                        r_ins_busy <= 1'b0; r_ins_done <= 1'b1;
                    end else begin
                        r_ins_ph <= 2'd1;
                        r_k <= (r_count < w_cap) ? r_count : w_cap - 6'd1;
                    end
                end else if (r_k > r_idx) begin
                    r_val[r_k[spp_pkg::IdxW-1:0]] <= r_val[r_k[spp_pkg::IdxW-1:0] - 5'd1];
                    r_pos[r_k[spp_pkg::IdxW-1:0]] <= r_pos[r_k[spp_pkg::IdxW-1:0] - 5'd1];
                    r_k <= r_k - 6'd1;
                end else begin
                    r_val[r_idx[spp_pkg::IdxW-1:0]] <= r_ins_val;
                    r_pos[r_idx[spp_pkg::IdxW-1:0]] <= r_ins_pos;
                    if (r_count < w_cap) r_count <= r_count + 6'd1;
                    r_ins_busy <= 1'b0; r_ins_done <= 1'b1;
                end
            end
        end
    end

    // output pointer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_ptr <= '0; r_out_cnt <= '0;
        end else if (i_cmd.out_load && r_out_ptr == '0 && r_out_cnt == '0) begin
            r_out_cnt <= (r_count < w_cap) ? r_count : w_cap;
        end else if (i_cmd.out_next) begin
            if (r_out_ptr + 6'd1 >= r_out_cnt) begin
                r_out_ptr <= '0; r_out_cnt <= '0;
            end else r_out_ptr <= r_out_ptr + 6'd1;
        end
    end

    assign o_peak_position = (r_out_cnt == '0) ? 16'd0 : r_pos[r_out_ptr[spp_pkg::IdxW-1:0]];
    assign o_peak_value    = (r_out_cnt == '0) ? 17'd0 : r_val[r_out_ptr[spp_pkg::IdxW-1:0]];
    assign o_peak_present  = (r_out_cnt != '0);

    assign o_sts.have_peak   = r_have_peak;
    assign o_sts.have_refine = r_have_ref;
    assign o_sts.have_edge   = r_have_edge;
    assign o_sts.div_done    = div_done && r_pass;
    assign o_sts.ins_done    = r_ins_done;
    assign o_sts.is_last     = r_last;
    assign o_sts.out_last    = (r_out_cnt == '0) || (r_out_ptr + 6'd1 >= r_out_cnt);
    assign o_sts.out_empty   = (r_out_cnt == '0);

    `SPP_ASSERT_IMP(a_count_cap, i_clk, i_rst_n, !r_ins_busy && !i_cmd.ins_start,
        r_count <= 6'(spp_pkg::MaxPeaks), "peak count beyond list depth")
    `SPP_ASSERT_NXT(a_ins_ends, i_clk, i_rst_n, r_ins_done, !r_ins_busy,
        "insertion still busy after done")
    `SPP_ASSERT_IMP(a_ptr_range, i_clk, i_rst_n, r_out_cnt != '0, r_out_ptr < r_out_cnt,
        "output pointer beyond count")
endmodule

FILE: design/spp_ctrl.sv
// Controller state machine sequencing bin, divide, insertion and emission
`timescale 1ns / 1ps
`include "spectral_peak_picker_top_n_core_macros.svh"
module spp_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output spp_pkg::t_cmd o_cmd,
    input  spp_pkg::t_sts i_sts
);
    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_EVAL = 6'b000010,
        S_DIV  = 6'b000100,
        S_INS  = 6'b001000,
        S_LOAD = 6'b010000,
        S_OUT  = 6'b100000
    } t_state;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else r_state <= n_state;
    end

    always_comb begin
        n_state = r_state;
        o_cmd = '0;
        o_in_ready = 1'b0;
        o_out_valid = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.take_bin = 1'b1;
                    n_state = S_EVAL;
                end
            end
            S_EVAL: begin
                if (i_sts.have_refine) begin
                    o_cmd.div_start = 1'b1;
                    n_state = S_DIV;
                end else if (i_sts.have_peak || i_sts.have_edge) begin
                    o_cmd.ins_start = 1'b1;
                    n_state = S_INS;
                end else if (i_sts.is_last) begin
                    n_state = S_LOAD;
                end else n_state = S_IDLE;
            end
            S_DIV: if (i_sts.div_done) n_state = S_EVAL;
                   else if (!i_sts.have_refine) n_state = S_EVAL;
            S_INS: if (i_sts.ins_done) n_state = S_EVAL;
            S_LOAD: begin
                o_cmd.out_load = 1'b1;
                n_state = S_OUT;
            end
            S_OUT: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    if (i_sts.out_last) begin
                        o_cmd.frame_clear = 1'b1;
                        n_state = S_IDLE;
                    end
                    if (!i_sts.out_empty) o_cmd.out_next = 1'b1;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    `SPP_ASSERT_IMP(a_no_overlap, i_clk, i_rst_n, o_in_ready, !o_out_valid,
        "input and output open together")
    `SPP_ASSERT_NXT(a_take_eval, i_clk, i_rst_n, o_cmd.take_bin, r_state == S_EVAL,
        "bin not evaluated after take")
    `SPP_ASSERT_NXT(a_clear_idle, i_clk, i_rst_n, o_cmd.frame_clear, r_state == S_IDLE,
        "frame clear did not return to idle")
endmodule

FILE: design/spectral_peak_picker_top_n_core.sv
// Top level: Configuration registers plus controller and datapath
// Sequence: a bin without a peak passes through the idle and evaluate states; a peak adds a sorted
// insert bounded by cap, cap being wanted held to 1..32; a refined peak adds two divides.
// Results: out valid after the final bin's work, then one beat per peak or one empty beat.
// Throughput: one bin at a time; the divider and list shift set the per-peak cost.
// Reset: i_rst_n synchronous active low clears frame state, wanted 8, threshold 0.
`timescale 1ns / 1ps
module spectral_peak_picker_top_n_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [15:0] i_magnitude,
    input  logic        i_last_bin,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [15:0] o_peak_position,
    output logic [16:0] o_peak_value,
    output logic        o_peak_present,
    output logic        o_last_peak,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [15:0] i_cfg_data
);
    logic [5:0]  r_wanted;
    logic [15:0] r_thresh;
    spp_pkg::t_cmd w_cmd;
    spp_pkg::t_sts w_sts;

    assign o_cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wanted <= 6'd8;
            r_thresh <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                spp_pkg::CFG_WANTED: r_wanted <= i_cfg_data[5:0];
                spp_pkg::CFG_THRESH: r_thresh <= i_cfg_data;
                default: ;
            endcase
        end
    end

    spp_ctrl u_ctrl (.i_clk, .i_rst_n, .i_in_valid, .o_in_ready, .o_out_valid,
                     .i_out_ready, .o_cmd(w_cmd), .i_sts(w_sts));

    spp_datapath u_dp (.i_clk, .i_rst_n, .i_cmd(w_cmd), .o_sts(w_sts),
                       .i_magnitude, .i_last_bin, .i_wanted(r_wanted),
                       .i_thresh(r_thresh), .o_peak_position, .o_peak_value,
                       .o_peak_present);

    assign o_last_peak = w_sts.out_last;
endmodule

FILE: bench/spectral_peak_picker_top_n_core_checker.sv
// Checker for the spectral peak picker: watches all channels, predicts and compares peaks
`timescale 1ns / 1ps
module spectral_peak_picker_top_n_core_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [15:0] i_magnitude,
    input  logic        i_last_bin,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [15:0] i_peak_position,
    input  logic [16:0] i_peak_value,
    input  logic        i_peak_present,
    input  logic        i_last_peak,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [15:0] i_cfg_data,
    output int          o_errors,
    output int          o_pending
);
    typedef struct packed {
        logic [15:0] position;
        logic [16:0] value;
        logic        present;
        logic        last;
    } t_peak_beat;

    t_peak_beat  expected_peaks[$];

    // shadow copy of configuration and frame tracking
    int unsigned wanted_cnt;
    int unsigned thresh;
    int unsigned bin_idx;
    int unsigned prev_mag;
    int unsigned prev2_mag;
    int unsigned plateau_at;
    bit          rising;
    int unsigned ranked_cnt;
    logic [16:0] ranked_val [spp_pkg::MaxPeaks];
    logic [15:0] ranked_pos [spp_pkg::MaxPeaks];

    assign o_pending = expected_peaks.size();

    function automatic int unsigned keep_cap();
        int unsigned c;
        c = wanted_cnt;
        if (c < 1) c = 1;
        if (c > spp_pkg::MaxPeaks) c = spp_pkg::MaxPeaks;
        return c;
    endfunction

    task automatic clear_frame();
        bin_idx    = 0;
        prev_mag   = 0;
        prev2_mag  = 0;
        plateau_at = 0;
        rising     = 0;
        ranked_cnt = 0;
    endtask

    // sorted insert: descending value, equal values keep the earlier peak first
    task automatic rank_peak(input int unsigned pos, input int unsigned val);
        int unsigned cap;
        int unsigned idx;
        int unsigned k;
        cap = keep_cap();
        idx = 0;
        if (ranked_cnt > cap) ranked_cnt = cap;
        while (idx < ranked_cnt && ranked_val[idx] >= val) idx++;
        if (idx >= cap) return;
        k = (ranked_cnt < cap) ? ranked_cnt : cap - 1;
        for (; k > idx; k--) begin
            ranked_val[k] = ranked_val[k-1];
            ranked_pos[k] = ranked_pos[k-1];
        end
        ranked_val[idx] = val[16:0];
        ranked_pos[idx] = pos[15:0];
        if (ranked_cnt < cap) ranked_cnt++;
    endtask

    // parabolic refinement of a strict maximum at bin j
    task automatic rank_parabola(input int l, input int m, input int r, input int j);
        int     d;
        int     dn;
        int     a;
        int     frac;
        int     pos;
        longint v;
        d  = 2 * m - l - r;
        dn = r - l;
        a  = (dn < 0) ? -dn : dn;
        if (d <= 0) return;
        frac = (16 * a + d) / (2 * d);
        pos  = j * 16 + ((dn < 0) ? -frac : frac);
        if (pos < 0) pos = 0;
        v = (longint'(a) * a + 4 * longint'(d)) / (8 * longint'(d)) + m;
        if (v > spp_pkg::ValSat) v = spp_pkg::ValSat;
        rank_peak(pos, int'(v));
    endtask

    // one accepted bin
    task automatic take_bin(input int unsigned x, input bit last_in);
        int unsigned n;
        int unsigned p;
        int unsigned j;
        int unsigned cnt;
        bit          last;
        t_peak_beat  b;
        n    = bin_idx;
        last = last_in;
        if (n >= spp_pkg::MaxBins - 1) last = 1;
        if (n >= 1) begin
            p = prev_mag;
            if (n == 1 && p > x && p > thresh) rank_peak(0, p);
            if (n >= 2 && x < p && rising && p > thresh) begin
                j = n - 1;
                if (plateau_at == j) rank_parabola(prev2_mag, p, x, j);
                else if (!last) rank_peak((plateau_at + j) * 8, p);
            end
            if (x < p) begin
                rising = 0;
            end else if (x > p) begin
                rising     = 1;
                plateau_at = n;
            end
            if (last && x > p && x > thresh) rank_peak(n * 16, x);
        end
        prev2_mag = prev_mag;
        prev_mag  = x;
        if (!last) begin
            bin_idx = n + 1;
            return;
        end
        cnt = (ranked_cnt < keep_cap()) ? ranked_cnt : keep_cap();
        if (cnt == 0) begin
            b = '{position: '0, value: '0, present: 1'b0, last: 1'b1};
            expected_peaks.insert(expected_peaks.size(), b);
        end
        for (int k = 0; k < cnt; k++) begin
            b = '{position: ranked_pos[k], value: ranked_val[k], present: 1'b1,
                  last: (k + 1 == cnt)};
            expected_peaks.insert(expected_peaks.size(), b);
        end
        clear_frame();
    endtask

    // watch the three channels
    always @(posedge i_clk) begin
        t_peak_beat e;
        if (!i_rst_n) begin
            wanted_cnt = 8;
            thresh     = 0;
            clear_frame();
            expected_peaks.delete();
            o_errors <= 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index == spp_pkg::CFG_WANTED) wanted_cnt = i_cfg_data[5:0];
                else thresh = i_cfg_data;
            end
            if (i_in_valid && i_in_ready) take_bin(i_magnitude, i_last_bin);
            if (i_out_valid && i_out_ready) begin
                if (expected_peaks.size() == 0) begin
                    $display("%0t: unexpected beat pos %h val %h present %b last %b", $time,
                             i_peak_position, i_peak_value, i_peak_present, i_last_peak);
                    o_errors <= o_errors + 1;
                end else begin
                    e = expected_peaks.pop_front();
                    if (e.position !== i_peak_position || e.value !== i_peak_value ||
                        e.present !== i_peak_present || e.last !== i_last_peak) begin
                        $display("%0t: mismatch expected pos %h val %h present %b last %b",
                                 $time, e.position, e.value, e.present, e.last);
                        $display("%0t:          actual   pos %h val %h present %b last %b",
                                 $time, i_peak_position, i_peak_value, i_peak_present,
                                 i_last_peak);
                        o_errors <= o_errors + 1;
                    end
                end
            end
        end
    end
endmodule

FILE: bench/spectral_peak_picker_top_n_core_test.sv
// Stimulus, flow control and verdict for the spectral peak picker
`timescale 1ns / 1ps
module spectral_peak_picker_top_n_core_test;

    localparam int StallLimit = 6000;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    logic [15:0] i_magnitude;
    logic        i_last_bin;
    logic        o_out_valid;
    logic        i_out_ready;
    logic [15:0] o_peak_position;
    logic [16:0] o_peak_value;
    logic        o_peak_present;
    logic        o_last_peak;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic        i_cfg_index;
    logic [15:0] i_cfg_data;

    int          errors;
    int          pending;
    bit          no_idle;
    int          hold_requests;
    int          hold_served;
    int          hold_left;
    int          quiet_cycles;
    int unsigned frame_mag [$];

    spectral_peak_picker_top_n_core uut (.*);

    spectral_peak_picker_top_n_core_checker peak_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .i_in_ready      (o_in_ready),
        .i_magnitude     (i_magnitude),
        .i_last_bin      (i_last_bin),
        .i_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .i_peak_position (o_peak_position),
        .i_peak_value    (o_peak_value),
        .i_peak_present  (o_peak_present),
        .i_last_peak     (o_last_peak),
        .i_cfg_valid     (i_cfg_valid),
        .i_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .o_errors        (errors),
        .o_pending       (pending)
    );

    initial begin
        i_clk = 0;
        forever #6 i_clk = ~i_clk;
    end

    // receiver: random stalls, plus a long hold-off on request
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 0;
            hold_served <= 0;
            hold_left   <= 0;
        end else if (hold_served != hold_requests) begin
            hold_served <= hold_requests;
            hold_left   <= 500;
            i_out_ready <= 0;
        end else if (hold_left > 0) begin
            hold_left   <= hold_left - 1;
            i_out_ready <= 0;
        end else begin
            i_out_ready <= no_idle || ($urandom_range(99) >= 36);
        end
    end

    // watchdog on cycles with no beat on any channel
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= StallLimit) begin
            $display("spectral_peak_picker_top_n_core_test: errors");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // one bin beat; a gap only ever lowers valid in a step of its own
    task automatic send_bin(input logic [15:0] mag, input bit last);
        bit taken;
        if (!no_idle && $urandom_range(99) < 36) begin
            i_in_valid <= 0;
            repeat ($urandom_range(3, 1)) @(posedge i_clk);
        end
        i_in_valid  <= 1;
        i_magnitude <= mag;
        i_last_bin  <= last;
        // ready only moves at the clock, so mid-cycle sampling is race free
        do begin
            @(negedge i_clk);
            taken = o_in_ready;
            @(posedge i_clk);
        end while (!taken);
    endtask

    task automatic send_frame();
        for (int k = 0; k < frame_mag.size(); k++)
            send_bin(frame_mag[k], k == frame_mag.size() - 1);
        frame_mag.delete();
    endtask

    // only between frames, once all peaks are out and the block has settled
    task automatic write_reg(input logic idx, input logic [15:0] data);
        i_in_valid <= 0;
        do @(posedge i_clk); while (pending != 0);
        repeat (250) @(posedge i_clk);
        i_cfg_valid <= 1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 0;
    endtask

    // random frame: full noise, plateau-rich walks, near-threshold or extremes
    task automatic random_frame(input int len, input int unsigned thr);
        int unsigned kind;
        int          v;
        kind = $urandom_range(3);
        v    = $urandom_range(65535);
        for (int k = 0; k < len; k++) begin
            case (kind)
                0: v = $urandom_range(65535);
                1: begin
                    if ($urandom_range(3) != 0) v = v + $urandom_range(8000) - 4000;
                    if (v < 0) v = 0;
                    if (v > 65535) v = 65535;
                end
                2: begin
                    v = int'(thr) + $urandom_range(6) - 3;
                    if (v < 0) v = 0;
                    if (v > 65535) v = 65535;
                end
                default: v = $urandom_range(1) ? 65535 : $urandom_range(2);
            endcase
            frame_mag.insert(frame_mag.size(), v);
        end
    endtask

    task automatic random_phase(input int items, input int unsigned thr);
        int sent;
        int len;
        sent = 0;
        while (sent < items) begin
            len = ($urandom_range(15) == 0) ? 1 : $urandom_range(24, 2);
            random_frame(len, thr);
            send_frame();
            sent += len;
        end
    endtask

    initial begin
        i_rst_n       = 0;
        i_in_valid    = 0;
        i_magnitude   = 0;
        i_last_bin    = 0;
        i_cfg_valid   = 0;
        i_cfg_index   = spp_pkg::CFG_WANTED;
        i_cfg_data    = 0;
        no_idle       = 0;
        hold_requests = 0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // directed: edge peaks, short frames, plateaus, strict maxima
        frame_mag = '{16'hFFFF, 16'h0000};  send_frame();  // falling from bin 0
        frame_mag = '{16'h0000, 16'hFFFF};  send_frame();  // rising into final bin
        frame_mag = '{16'h1234};            send_frame();  // one bin, empty result
        frame_mag = '{1, 5, 5, 5, 2, 3};    send_frame();  // plateau, then final rise
        frame_mag = '{1, 5, 5, 2};          send_frame();  // plateau falling into final
        frame_mag = '{5, 5, 2, 2};          send_frame();  // flat start, no rise
        frame_mag = '{0, 16'hFFFF, 16'hFFFE, 7}; send_frame(); // full-scale strict max
        frame_mag = '{1, 9, 3};             send_frame();  // strict max before final
        write_reg(spp_pkg::CFG_THRESH, 16'hFFFE);
        frame_mag = '{0, 16'hFFFF, 0, 16'hFFFE, 0}; send_frame(); // only one clears
        write_reg(spp_pkg::CFG_THRESH, 16'hFFFF);
        frame_mag = '{0, 16'hFFFF, 0};      send_frame();  // nothing exceeds
        write_reg(spp_pkg::CFG_THRESH, 0);

        // wanted counts at and past the limits
        write_reg(spp_pkg::CFG_WANTED, 1);
        random_phase(40, 0);
        write_reg(spp_pkg::CFG_WANTED, 0);
        random_phase(30, 0);
        write_reg(spp_pkg::CFG_WANTED, 63);
        write_reg(spp_pkg::CFG_THRESH, 16'h8000);
        random_phase(40, 16'h8000);

        // full list, then the receiver held off while the input keeps offering
        write_reg(spp_pkg::CFG_WANTED, 32);
        write_reg(spp_pkg::CFG_THRESH, 0);
        for (int k = 0; k < 80; k++)
            frame_mag.insert(frame_mag.size(), (k % 2) ? 100 + k * 7 : 10);
        for (int k = 0; k < 79; k++) send_bin(frame_mag[k], 0);
        hold_requests <= hold_requests + 1;
        send_bin(frame_mag[79], 1);
        frame_mag.delete();
        random_phase(30, 0);

        // long stretch with no idling on either side
        no_idle = 1;
        write_reg(spp_pkg::CFG_WANTED, 5);
        random_phase(50, 0);
        no_idle = 0;

        write_reg(spp_pkg::CFG_WANTED, 8);
        write_reg(spp_pkg::CFG_THRESH, 16'($urandom_range(20000)));
        random_phase(30, 0);
        write_reg(spp_pkg::CFG_WANTED, 3);
        write_reg(spp_pkg::CFG_THRESH, 0);
        random_phase(20, 0);

        // drain, then let the block settle
        i_in_valid <= 0;
        do @(posedge i_clk); while (pending != 0);
        repeat (300) @(posedge i_clk);
        if (errors == 0) begin
            $display("spectral_peak_picker_top_n_core_test: clean");
        end else begin
            $display("spectral_peak_picker_top_n_core_test: errors");
        end
        $finish;
    end
endmodule

FILE: files.f
+incdir+design
design/spp_pkg.sv
design/spp_divider.sv
design/spp_datapath.sv
design/spp_ctrl.sv
design/spectral_peak_picker_top_n_core.sv
bench/spectral_peak_picker_top_n_core_checker.sv
bench/spectral_peak_picker_top_n_core_test.sv
